// File: rtl/core/ps2_mouse_cursor_tracker_core_defines.svh
// Assertion macros shared by the PS/2 mouse cursor tracker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PS2MCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define PS2MCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ps2mct_pkg.sv
// Package for the PS/2 mouse cursor tracker: widths, codes and shared types.
// No dependencies; used by ps2mct_clamp and ps2_mouse_cursor_tracker_core.
`timescale 1ns / 1ps

package ps2mct_pkg;

   // cursor position width and derived arithmetic width
   localparam int COORD_BITS  = 12;
   localparam int SUM_W       = COORD_BITS + 3;
   localparam int CURSOR_BITS = 11;
   localparam int DELTA_W     = 9;

   // register widths
   localparam int RES_W  = 12;
   localparam int SIZE_W = 8;

   // channel widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_MARGIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_MARGIN  = 3'd5;

   // register reset values
   localparam logic [RES_W-1:0]  RST_SCREEN_WIDTH  = 12'd1024;
   localparam logic [RES_W-1:0]  RST_SCREEN_HEIGHT = 12'd768;
   localparam logic [SIZE_W-1:0] RST_CURSOR_SIZE   = 8'd22;
   localparam logic [SIZE_W-1:0] RST_MARGIN        = 8'd0;

   // byte position within a packet
   localparam logic [1:0] IDX_HEADER = 2'd0;
   localparam logic [1:0] IDX_XDELTA = 2'd1;
   localparam logic [1:0] IDX_YDELTA = 2'd2;
   localparam logic [1:0] IDX_STRAY  = 2'd3;

   // header bits
   localparam int HDR_SYNC_BIT = 3;
   localparam int HDR_XSIGN    = 4;
   localparam int HDR_YSIGN    = 5;

   // fixed margin in menu mode, start position
   localparam logic [SIZE_W-1:0]     MENU_MARGIN = 8'd5;
   localparam logic [COORD_BITS-1:0] POS_X_RST   = COORD_BITS'(512);
   localparam logic [COORD_BITS-1:0] POS_Y_RST   = COORD_BITS'(384);

   // largest position, in the signed arithmetic width
   localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((1 << COORD_BITS) - 1);

   // limits for one axis
   typedef struct packed {
      logic [SIZE_W-1:0] lo;
      logic [RES_W-1:0]  res;
      logic [SIZE_W-1:0] hi_margin;
      logic [SIZE_W-1:0] size;
   } clamp_bounds_type;

endpackage

// File: rtl/core/ps2_mouse_cursor_tracker_core.sv
// Top level of the PS/2 mouse cursor tracker: packet framing, cursor state, handshakes.
// Depends on ps2mct_pkg, ps2mct_clamp and ps2_mouse_cursor_tracker_core_defines.svh.
//
//   port group | direction | tdata / data            | tuser
//   req_       | in        | data_byte               | menu_mode
//   rsp_       | out       | cursor_x, y, buttons    | packet_done, byte_dropped
//   csr_       | in        | register write (index)  | -
//
// One request per cycle sustained while responses are taken; each request gives one
// response (input register, then one add-and-clamp pass into the output register).
// The cursor and packet state update in that same pass, so requests follow back to back.
// Reset (synchronous, high) restores register defaults, start position 512/384, empty
// pipeline. A stalled response holds the output register; the input register still
// takes one more request, then req_tready drops until the response moves on.
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2_mouse_cursor_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   // request: [7:0] data_byte
   input  logic [ps2mct_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request user: [0] menu_mode
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // response: [10:0] cursor_x, [21:11] cursor_y, [22] button_left,
   // [23] button_right, [24] button_middle, [31:25] zero
   output logic [ps2mct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // response user: [0] packet_done, [1] byte_dropped
   output logic [ps2mct_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ps2mct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ps2mct_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ps2mct_pkg::*;

   // configuration registers
   logic [RES_W-1:0]  screen_width_ff;
   logic [RES_W-1:0]  screen_height_ff;
   logic [SIZE_W-1:0] cursor_width_ff;
   logic [SIZE_W-1:0] cursor_height_ff;
   logic [SIZE_W-1:0] edge_margin_ff;
   logic [SIZE_W-1:0] right_margin_ff;

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  in_menu_ff;
   logic                  req_take;
   logic                  advance;

   // tracker state
   logic [1:0]            byte_index_ff, byte_index_in;
   logic [7:0]            header_ff, header_in;
   logic [7:0]            x_delta_ff, x_delta_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [2:0]            buttons_ff, buttons_in;
   logic                  done_in;
   logic                  dropped_in;

   // output stage
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [CURSOR_BITS-1:0] out_x_ff, out_x_in;
   logic [CURSOR_BITS-1:0] out_y_ff, out_y_in;
   logic [2:0]             out_buttons_ff;
   logic                   out_done_ff;
   logic                   out_dropped_ff;

   // axis datapath
   logic [DELTA_W-1:0]     dx;
   logic [DELTA_W-1:0]     dy;
   clamp_bounds_type       x_bounds;
   clamp_bounds_type       y_bounds;
   logic [COORD_BITS-1:0]  x_clamped;
   logic [COORD_BITS-1:0]  y_clamped;
   logic [COORD_BITS+CURSOR_BITS-1:0] x_wide;
   logic [COORD_BITS+CURSOR_BITS-1:0] y_wide;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         cursor_width_ff  <= RST_CURSOR_SIZE;
         cursor_height_ff <= RST_CURSOR_SIZE;
         edge_margin_ff   <= RST_MARGIN;
         right_margin_ff  <= RST_MARGIN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_data[RES_W-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_data[RES_W-1:0];
            REG_CURSOR_WIDTH:  cursor_width_ff  <= csr_data[SIZE_W-1:0];
            REG_CURSOR_HEIGHT: cursor_height_ff <= csr_data[SIZE_W-1:0];
            REG_EDGE_MARGIN:   edge_margin_ff   <= csr_data[SIZE_W-1:0];
            REG_RIGHT_MARGIN:  right_margin_ff  <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline handshakes
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
         in_menu_ff <= req_tuser;
      end
   end

   // sign-extended deltas and per-axis limits
   assign dx = {header_ff[HDR_XSIGN], x_delta_ff};
   assign dy = {header_ff[HDR_YSIGN], in_data_ff};

   assign x_bounds.lo        = in_menu_ff ? MENU_MARGIN : edge_margin_ff;
   assign x_bounds.res       = screen_width_ff;
   assign x_bounds.hi_margin = in_menu_ff ? MENU_MARGIN : right_margin_ff;
   assign x_bounds.size      = cursor_width_ff;

   assign y_bounds.lo        = in_menu_ff ? MENU_MARGIN : edge_margin_ff;
   assign y_bounds.res       = screen_height_ff;
   assign y_bounds.hi_margin = in_menu_ff ? MENU_MARGIN : edge_margin_ff;
   assign y_bounds.size      = cursor_height_ff;

   ps2mct_clamp u_clamp_x (
      .pos     (pos_x_ff),
      .delta   (dx),
      .negate  (1'b0),
      .bounds  (x_bounds),
      .pos_out (x_clamped)
   );

   ps2mct_clamp u_clamp_y (
      .pos     (pos_y_ff),
      .delta   (dy),
      .negate  (1'b1),
      .bounds  (y_bounds),
      .pos_out (y_clamped)
   );

   // packet framing and cursor update
   always_comb begin
      byte_index_in = byte_index_ff;
      header_in     = header_ff;
      x_delta_in    = x_delta_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      buttons_in    = buttons_ff;
      done_in       = 1'b0;
      dropped_in    = 1'b0;
      unique case (byte_index_ff)
         IDX_HEADER: begin
            if (!in_data_ff[HDR_SYNC_BIT]) begin
               dropped_in = 1'b1;
            end else begin
               header_in     = in_data_ff;
               byte_index_in = IDX_XDELTA;
            end
         end
         IDX_XDELTA: begin
            x_delta_in    = in_data_ff;
            byte_index_in = IDX_YDELTA;
         end
         // third byte, and the unreachable stray index
         IDX_YDELTA, IDX_STRAY: begin
            buttons_in = header_ff[2:0];
            if (dx != '0) begin
               pos_x_in = x_clamped;
            end
            if (dy != '0) begin
               pos_y_in = y_clamped;
            end
            byte_index_in = IDX_HEADER;
            done_in       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= IDX_HEADER;
         header_ff     <= '0;
         x_delta_ff    <= '0;
         pos_x_ff      <= POS_X_RST;
         pos_y_ff      <= POS_Y_RST;
         buttons_ff    <= '0;
      end else if (advance) begin
         byte_index_ff <= byte_index_in;
         header_ff     <= header_in;
         x_delta_ff    <= x_delta_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         buttons_ff    <= buttons_in;
      end
   end

   // low cursor bits, zero-filled for narrow positions
   assign x_wide   = {{CURSOR_BITS{1'b0}}, pos_x_in};
   assign y_wide   = {{CURSOR_BITS{1'b0}}, pos_y_in};
   assign out_x_in = x_wide[CURSOR_BITS-1:0];
   assign out_y_in = y_wide[CURSOR_BITS-1:0];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff       <= out_x_in;
         out_y_ff       <= out_y_in;
         out_buttons_ff <= buttons_in;
         out_done_ff    <= done_in;
         out_dropped_ff <= dropped_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*CURSOR_BITS-3){1'b0}}, out_buttons_ff,
                        out_y_ff, out_x_ff};
   assign rsp_tuser  = {out_dropped_ff, out_done_ff};

   // checks
   `PS2MCT_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_tready, !req_tready,
      "request taken while both stages are stalled")
   `PS2MCT_ASSERT_NOW(a_done_xor_dropped, clock, reset,
      out_valid_ff, !(out_done_ff && out_dropped_ff),
      "response marked both packet done and byte dropped")
   `PS2MCT_ASSERT_NEXT(a_packet_wraps, clock, reset,
      advance && byte_index_ff[1], byte_index_ff == IDX_HEADER,
      "byte index did not wrap after the third byte")
   `PS2MCT_ASSERT_NEXT(a_state_holds, clock, reset,
      !advance, $stable(pos_x_ff) && $stable(pos_y_ff) && $stable(byte_index_ff),
      "tracker state changed without a request in flight")

endmodule

// File: rtl/core/ps2mct_clamp.sv
// One cursor axis: applies a 9-bit delta and clamps against margins and screen size.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

module ps2mct_clamp (
   input  logic [ps2mct_pkg::COORD_BITS-1:0]      pos,
   input  logic [ps2mct_pkg::DELTA_W-1:0]         delta,
   input  logic                                   negate,
   input  ps2mct_pkg::clamp_bounds_type           bounds,
   output logic [ps2mct_pkg::COORD_BITS-1:0]      pos_out
);
   import ps2mct_pkg::*;

   logic signed [SUM_W-1:0] pos_ext;
   logic signed [SUM_W-1:0] delta_ext;
   logic signed [SUM_W-1:0] moved;
   logic signed [SUM_W-1:0] lo_ext;
   logic signed [SUM_W-1:0] limit;
   logic signed [SUM_W-1:0] bounded;

   // widen everything into one signed width
   assign pos_ext   = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos});
   assign delta_ext = $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
   assign lo_ext    = $signed({{(SUM_W-SIZE_W){1'b0}}, bounds.lo});
   assign moved     = negate ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

   // far edge: resolution less margin less cursor size
   assign limit = $signed({{(SUM_W-RES_W){1'b0}}, bounds.res})
                - $signed({{(SUM_W-SIZE_W){1'b0}}, bounds.hi_margin})
                - $signed({{(SUM_W-SIZE_W){1'b0}}, bounds.size});

   // near edge wins, then far edge
   always_comb begin
      if (moved < lo_ext) begin
         bounded = lo_ext;
      end else if (moved > limit) begin
         bounded = limit;
      end else begin
         bounded = moved;
      end
   end

   // saturate into the position range
   always_comb begin
      if (bounded < 0) begin
         pos_out = '0;
      end else if (bounded > COORD_MAX) begin
         pos_out = COORD_MAX[COORD_BITS-1:0];
      end else begin
         pos_out = bounded[COORD_BITS-1:0];
      end
   end

endmodule
